// ===== rtl/cnfst_pkg.sv =====
// Shared types and constants for the CNF clause satisfaction tracker.
`timescale 1ns / 1ps

package cnfst_pkg;

  localparam int CLAUSE_IDX_W = 10;
  localparam int SLOT_W       = 2;
  localparam int VAR_W        = 8;
  localparam int VAL_W        = 2;
  localparam int COUNT_W      = 11;
  localparam int NVARS_W      = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 11;

  // Variable values
  localparam logic [VAL_W-1:0] VAL_FALSE      = 2'd0;
  localparam logic [VAL_W-1:0] VAL_TRUE       = 2'd1;
  localparam logic [VAL_W-1:0] VAL_UNASSIGNED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLAUSES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS    = 2'd1;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_ASSIGN = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // One literal slot: variable number (0 = empty) and negation
  typedef struct packed {
    logic             neg;
    logic [VAR_W-1:0] vnum;
  } lit_t;

  // Flag update decided for one clause
  typedef struct packed {
    logic set;
    logic clr;
  } upd_t;

endpackage

// ===== rtl/cnfst_if.sv =====
// Handshake channel interfaces: input items, results and configuration writes.
`timescale 1ns / 1ps

interface cnfst_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic [cnfst_pkg::CLAUSE_IDX_W-1:0]   clause_index;
  logic [cnfst_pkg::SLOT_W-1:0]         lit_slot;
  logic [cnfst_pkg::VAR_W-1:0]          var_index;
  logic                                 negated;
  logic [cnfst_pkg::VAL_W-1:0]          value;

  modport source (output valid, op, clause_index, lit_slot, var_index, negated, value,
                  input ready);
  modport sink   (input valid, op, clause_index, lit_slot, var_index, negated, value,
                  output ready);
endinterface

interface cnfst_out_if;
  logic                            valid;
  logic                            ready;
  logic [cnfst_pkg::COUNT_W-1:0]   satisfied_count;
  logic                            all_satisfied;
  logic                            bad_index;

  modport source (output valid, satisfied_count, all_satisfied, bad_index, input ready);
  modport sink   (input valid, satisfied_count, all_satisfied, bad_index, output ready);
endinterface

interface cnfst_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cnfst_pkg::CFG_IDX_W-1:0]    idx;
  logic [cnfst_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

// ===== rtl/cnfst_clause_eval.sv =====
// Clause evaluator: decides whether one clause's truth flag must be set or cleared.
`timescale 1ns / 1ps

module cnfst_clause_eval #(
  parameter int MAX_LITS = 4
) (
  input  cnfst_pkg::lit_t [MAX_LITS-1:0]                     lits,
  input  logic [MAX_LITS-1:0][cnfst_pkg::VAL_W-1:0]          vals,
  input  logic [cnfst_pkg::VAR_W-1:0]                        asg_var,
  input  logic                                               flag,
  output cnfst_pkg::upd_t                                    upd
);

  logic [MAX_LITS-1:0] hold;
  logic [MAX_LITS-1:0] match;
  logic                sat;
  logic                holds;

  always_comb begin
    for (int l = 0; l < MAX_LITS; l++) begin
      hold[l]  = (lits[l].vnum == asg_var);
      match[l] = (lits[l].vnum != '0) &&
                 (lits[l].neg ? (vals[l] == cnfst_pkg::VAL_FALSE)
                              : (vals[l] == cnfst_pkg::VAL_TRUE));
    end
    sat     = |match;
    holds   = |hold;
    upd.set = holds && sat && !flag;
    upd.clr = holds && !sat && flag;
  end

endmodule

// ===== rtl/cnf_clause_satisfaction_tracker_unit.sv =====
// Top level of the CNF clause satisfaction tracker.
// A load transaction, or an assign transaction that is rejected, goes straight to the
// result state, which registers its result once the output register is free. A valid
// assign stores the variable's value, then rescans the clause table one clause per cycle
// through the literal memory's single read port before its result is registered; the block
// takes no input item meanwhile. After reset a clearing pass over all MAX_CLAUSES entries
// zeroes the clause truth flags before the first input item is accepted; configuration
// writes are taken at all times. Load the whole clause table before the first assign:
// unwritten slots read back undefined.
`timescale 1ns / 1ps

module cnf_clause_satisfaction_tracker_unit #(
  parameter int MAX_CLAUSES = 1024,
  parameter int MAX_LITS    = 4,
  parameter int MAX_VARS    = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  cnfst_in_if.sink           in_ch,
  cnfst_out_if.source        out_ch,
  cnfst_cfg_if.sink          cfg_ch
);

  localparam int SC_W   = $clog2(MAX_CLAUSES + 1);
  localparam int CA_W   = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
  localparam int LS_W   = (MAX_LITS > 1) ? $clog2(MAX_LITS) : 1;
  localparam int VLIM   = (MAX_VARS < 255) ? MAX_VARS : 255;
  localparam int VDEPTH = VLIM + 1;
  localparam int VA_W   = $clog2(VDEPTH);

  // Control
  cnfst_pkg::state_t state_r, state_nxt;
  logic              in_rdy;
  logic              in_acc;
  logic              issue;
  logic              post;
  logic              ld_bad;
  logic              as_bad;
  logic              ld_we;
  logic              as_we;

  // Registers
  logic [cnfst_pkg::COUNT_W-1:0] num_clauses_r;
  logic [cnfst_pkg::NVARS_W-1:0] num_vars_r;
  logic [SC_W-1:0]               clr_r;
  logic [SC_W-1:0]               idx_r;
  logic [SC_W-1:0]               lim_r;
  logic [SC_W-1:0]               lim_nxt;
  logic [SC_W-1:0]               cnt_r;
  logic [cnfst_pkg::VAR_W-1:0]   asg_var_r;
  logic                          bad_r;

  // Scan pipeline
  logic                                      p1_r, p2_r;
  cnfst_pkg::lit_t [MAX_LITS-1:0]            lw_r, lw2_r;
  logic                                      fl_r, fl2_r;
  logic [CA_W-1:0]                           a1_r, a2_r;
  logic [MAX_LITS-1:0][cnfst_pkg::VAL_W-1:0] vval_r;
  logic [MAX_LITS-1:0]                       vok_r;
  logic [MAX_LITS-1:0][cnfst_pkg::VAL_W-1:0] veff;
  cnfst_pkg::upd_t                           upd;

  // Output register
  logic                          out_valid_r;
  logic [cnfst_pkg::COUNT_W-1:0] out_cnt_r;
  logic                          out_all_r;
  logic                          out_bad_r;

  // Storage
  cnfst_pkg::lit_t [MAX_LITS-1:0] lit_mem  [MAX_CLAUSES];
  logic                           flag_mem [MAX_CLAUSES];
  logic [cnfst_pkg::VAL_W-1:0]    var_bank [MAX_LITS][VDEPTH];
  logic [VDEPTH-1:0]              vvalid_r;

  cnfst_pkg::lit_t             wlit;
  logic [cnfst_pkg::VAL_W-1:0] sval;

  assign in_acc       = in_ch.valid && in_rdy;
  assign in_ch.ready  = in_rdy;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.satisfied_count = out_cnt_r;
  assign out_ch.all_satisfied   = out_all_r;
  assign out_ch.bad_index       = out_bad_r;

  // Item checks
  always_comb begin
    ld_bad = ({1'b0, in_ch.clause_index} >= num_clauses_r) ||
             (32'(in_ch.clause_index) >= 32'(MAX_CLAUSES)) ||
             (32'(in_ch.lit_slot) >= 32'(MAX_LITS)) ||
             (in_ch.var_index > num_vars_r) ||
             (32'(in_ch.var_index) > 32'(MAX_VARS));
    as_bad = (in_ch.var_index == '0) ||
             (in_ch.var_index > num_vars_r) ||
             (32'(in_ch.var_index) > 32'(MAX_VARS));
    wlit.neg  = in_ch.negated;
    wlit.vnum = in_ch.var_index;
    sval      = (in_ch.value > cnfst_pkg::VAL_UNASSIGNED) ? cnfst_pkg::VAL_UNASSIGNED
                                                           : in_ch.value;
    lim_nxt   = (32'(num_clauses_r) < 32'(MAX_CLAUSES)) ? SC_W'(num_clauses_r)
                                                         : SC_W'(MAX_CLAUSES);
  end

  assign ld_we = in_acc && (in_ch.op == cnfst_pkg::OP_LOAD) && !ld_bad;
  assign as_we = in_acc && (in_ch.op == cnfst_pkg::OP_ASSIGN) && !as_bad;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cnfst_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_rdy    = 1'b0;
    issue     = 1'b0;
    post      = 1'b0;
    unique case (state_r)
      cnfst_pkg::ST_CLEAR: begin
        if (clr_r == SC_W'(MAX_CLAUSES - 1)) state_nxt = cnfst_pkg::ST_IDLE;
      end
      cnfst_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          state_nxt = as_we ? cnfst_pkg::ST_SCAN : cnfst_pkg::ST_RESULT;
        end
      end
      cnfst_pkg::ST_SCAN: begin
        issue = (idx_r < lim_r);
        if (!issue && !p1_r && !p2_r) state_nxt = cnfst_pkg::ST_RESULT;
      end
      cnfst_pkg::ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          post      = 1'b1;
          state_nxt = cnfst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cnfst_pkg::ST_CLEAR;
    endcase
  end

  // Configuration, control counters, result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clauses_r <= '0;
      num_vars_r    <= '0;
      clr_r         <= '0;
      idx_r         <= '0;
      cnt_r         <= '0;
      bad_r         <= 1'b0;
      p1_r          <= 1'b0;
      p2_r          <= 1'b0;
      out_valid_r   <= 1'b0;
      vvalid_r      <= '0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.idx)
          cnfst_pkg::CFG_NUM_CLAUSES: num_clauses_r <= cfg_ch.data;
          cnfst_pkg::CFG_NUM_VARS:    num_vars_r    <= cfg_ch.data[cnfst_pkg::NVARS_W-1:0];
          default: ;
        endcase
      end
      if (state_r == cnfst_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (in_acc) begin
        bad_r <= (in_ch.op == cnfst_pkg::OP_LOAD) ? ld_bad : as_bad;
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (as_we) vvalid_r[VA_W'(in_ch.var_index)] <= 1'b1;
      p1_r <= issue;
      p2_r <= p1_r;
      if (p2_r && upd.set) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (p2_r && upd.clr) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (post) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      asg_var_r <= in_ch.var_index;
      lim_r     <= lim_nxt;
    end
    a1_r  <= idx_r[CA_W-1:0];
    a2_r  <= a1_r;
    lw2_r <= lw_r;
    fl2_r <= fl_r;
    if (post) begin
      out_cnt_r <= cnfst_pkg::COUNT_W'(cnt_r);
      out_all_r <= (32'(cnt_r) == 32'(num_clauses_r));
      out_bad_r <= bad_r;
    end
  end

  // Literal table: one clause word per address, one lane per literal slot
  always_ff @(posedge clk) begin
    if (ld_we) lit_mem[CA_W'(in_ch.clause_index)][LS_W'(in_ch.lit_slot)] <= wlit;
    lw_r <= lit_mem[idx_r[CA_W-1:0]];
  end

  // Clause truth flags, zeroed by the clearing pass
  always_ff @(posedge clk) begin
    if (state_r == cnfst_pkg::ST_CLEAR) begin
      flag_mem[clr_r[CA_W-1:0]] <= 1'b0;
    end else if (p2_r && (upd.set || upd.clr)) begin
      flag_mem[a2_r] <= upd.set;
    end
    fl_r <= flag_mem[idx_r[CA_W-1:0]];
  end

  // Variable values: one copy per literal lane, all written together
  always_ff @(posedge clk) begin
    for (int l = 0; l < MAX_LITS; l++) begin
      if (as_we) var_bank[l][VA_W'(in_ch.var_index)] <= sval;
      vval_r[l] <= var_bank[l][VA_W'(lw_r[l].vnum)];
      vok_r[l]  <= vvalid_r[VA_W'(lw_r[l].vnum)];
    end
  end

  always_comb begin
    for (int l = 0; l < MAX_LITS; l++) begin
      veff[l] = vok_r[l] ? vval_r[l] : cnfst_pkg::VAL_UNASSIGNED;
    end
  end

  cnfst_clause_eval #(
    .MAX_LITS (MAX_LITS)
  ) u_eval (
    .lits    (lw2_r),
    .vals    (veff),
    .asg_var (asg_var_r),
    .flag    (fl2_r),
    .upd     (upd)
  );

  // Checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(MAX_CLAUSES))
    else $error("satisfied count above clause capacity");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_r || p2_r) |-> (state_r == cnfst_pkg::ST_SCAN))
    else $error("scan pipeline busy outside scan");

  a_cnt_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(cnt_r)) |-> ($past(state_r) == cnfst_pkg::ST_SCAN))
    else $error("count changed outside scan");

  a_set_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    p2_r |-> !(upd.set && upd.clr))
    else $error("flag set and cleared together");

endmodule

// ===== tb/tb_cnf_clause_satisfaction_tracker_unit.sv =====
// Self-checking testbench for the CNF clause satisfaction tracker: directed rows, random phases.
`timescale 1ns / 1ps

module tb_cnf_clause_satisfaction_tracker_unit;

  localparam int N_CLAUSES   = 1024;
  localparam int N_LITS      = 4;
  localparam int N_VARS      = 255;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 60;
  localparam int MAX_REPORTS = 10;

  // value code above unassigned, stored as unassigned
  localparam logic [cnfst_pkg::VAL_W-1:0] VAL_RESERVED = 2'd3;

  typedef struct packed {
    cnfst_pkg::op_t                     op;
    logic [cnfst_pkg::CLAUSE_IDX_W-1:0] cidx;
    logic [cnfst_pkg::SLOT_W-1:0]       slot;
    logic [cnfst_pkg::VAR_W-1:0]        vidx;
    logic                               neg;
    logic [cnfst_pkg::VAL_W-1:0]        val;
  } item_t;

  typedef struct packed {
    logic [cnfst_pkg::COUNT_W-1:0] cnt;
    logic                          all_sat;
    logic                          bad;
  } tally_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t                        kind;
    item_t                            it;
    logic [cnfst_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [cnfst_pkg::CFG_DATA_W-1:0] reg_val;
    bit                               fixed;
    tally_t                           want;
  } row_t;

  typedef struct {
    int nc;
    int nv;
    int vpool;
    int n_items;
    bit calm;
  } phase_t;

  logic clk;
  logic rst_n;

  cnfst_in_if  in_ch();
  cnfst_out_if out_ch();
  cnfst_cfg_if cfg_ch();

  cnf_clause_satisfaction_tracker_unit #(
    .MAX_CLAUSES(N_CLAUSES),
    .MAX_LITS   (N_LITS),
    .MAX_VARS   (N_VARS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // shadow state of the tracker
  cnfst_pkg::lit_t                  lit_mem     [N_CLAUSES*N_LITS];
  bit                               slot_loaded [N_CLAUSES*N_LITS];
  logic [cnfst_pkg::VAL_W-1:0]      var_val     [N_VARS+1];
  bit                               clause_on   [N_CLAUSES];
  int unsigned                      true_cnt;
  logic [cnfst_pkg::CFG_DATA_W-1:0] nc_reg;
  logic [cnfst_pkg::NVARS_W-1:0]    nv_reg;

  tally_t tally_q[$];
  row_t   dir_tbl[$];
  phase_t plan[$];
  int     err_cnt;
  int     items_taken;
  bit     calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void miss(string s);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t: %s", $time, s);
  endfunction

  function automatic int clause_limit();
    return (nc_reg < N_CLAUSES) ? int'(nc_reg) : N_CLAUSES;
  endfunction

  function automatic bit lit_true(cnfst_pkg::lit_t l);
    if (l.vnum == 0) return 1'b0;
    if (l.neg) return var_val[l.vnum] == cnfst_pkg::VAL_FALSE;
    return var_val[l.vnum] == cnfst_pkg::VAL_TRUE;
  endfunction

  // re-evaluate every clause in range that holds variable v
  function automatic void rescore(logic [cnfst_pkg::VAR_W-1:0] v);
    bit holds;
    bit sat;
    for (int c = 0; c < clause_limit(); c++) begin
      holds = 1'b0;
      sat   = 1'b0;
      for (int s = 0; s < N_LITS; s++) begin
        if (lit_mem[c*N_LITS+s].vnum == v) holds = 1'b1;
        if (lit_true(lit_mem[c*N_LITS+s])) sat = 1'b1;
      end
      if (holds && sat != clause_on[c]) begin
        clause_on[c] = sat;
        if (sat) true_cnt++;
        else true_cnt--;
      end
    end
  endfunction

  function automatic tally_t track_clauses(item_t it);
    tally_t r;
    bit     bad;
    int     a;
    bad = 1'b0;
    a   = it.cidx * N_LITS + it.slot;
    // field widths already keep clause, slot and variable under the table limits
    if (it.op == cnfst_pkg::OP_LOAD) begin
      if (it.cidx >= nc_reg || it.vidx > nv_reg) bad = 1'b1;
      else begin
        lit_mem[a].neg  = it.neg;
        lit_mem[a].vnum = it.vidx;
        slot_loaded[a]  = 1'b1;
      end
    end else begin
      if (it.vidx == 0 || it.vidx > nv_reg) bad = 1'b1;
      else begin
        var_val[it.vidx] = (it.val > cnfst_pkg::VAL_UNASSIGNED) ? cnfst_pkg::VAL_UNASSIGNED
                                                                 : it.val;
        rescore(it.vidx);
      end
    end
    r.cnt     = true_cnt[cnfst_pkg::COUNT_W-1:0];
    r.all_sat = (true_cnt == nc_reg);
    r.bad     = bad;
    return r;
  endfunction

  function automatic int first_hole();
    for (int i = 0; i < clause_limit() * N_LITS; i++)
      if (!slot_loaded[i]) return i;
    return -1;
  endfunction

  function automatic item_t make_item(int vpool);
    item_t it;
    int    r;
    int    top;
    int    hole;
    top     = (nv_reg < vpool) ? int'(nv_reg) : vpool;
    it.cidx = cnfst_pkg::CLAUSE_IDX_W'($urandom);
    it.slot = cnfst_pkg::SLOT_W'($urandom);
    it.vidx = cnfst_pkg::VAR_W'($urandom);
    it.neg  = 1'($urandom);
    it.val  = cnfst_pkg::VAL_W'($urandom);
    it.op   = cnfst_pkg::op_t'($urandom_range(1));
    r       = $urandom_range(99);
    // a few percent stay fully random noise
    if (r >= 8) begin
      if (r < 40) begin
        it.op = cnfst_pkg::OP_LOAD;
        if (clause_limit() > 0)
          it.cidx = cnfst_pkg::CLAUSE_IDX_W'($urandom_range(clause_limit() - 1));
        it.vidx = ($urandom_range(99) < 15) ? '0 : cnfst_pkg::VAR_W'($urandom_range(top));
      end else begin
        it.op   = cnfst_pkg::OP_ASSIGN;
        it.vidx = cnfst_pkg::VAR_W'($urandom_range(top > 0 ? top : 1, 1));
      end
    end
    // a rescan must never read a slot that was never loaded: fill the table first
    hole = first_hole();
    if (it.op == cnfst_pkg::OP_ASSIGN && it.vidx != 0 && it.vidx <= nv_reg && hole >= 0) begin
      it.op   = cnfst_pkg::OP_LOAD;
      it.cidx = cnfst_pkg::CLAUSE_IDX_W'(hole / N_LITS);
      it.slot = cnfst_pkg::SLOT_W'(hole % N_LITS);
      it.vidx = cnfst_pkg::VAR_W'($urandom_range(top));
    end
    return it;
  endfunction

  function automatic row_t ld(int ci, int sl, int v, bit n);
    row_t r;
    r.kind    = ROW_ITEM;
    r.fixed   = 1'b0;
    r.want    = '0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.it.op   = cnfst_pkg::OP_LOAD;
    r.it.cidx = cnfst_pkg::CLAUSE_IDX_W'(ci);
    r.it.slot = cnfst_pkg::SLOT_W'(sl);
    r.it.vidx = cnfst_pkg::VAR_W'(v);
    r.it.neg  = n;
    r.it.val  = cnfst_pkg::VAL_W'($urandom);
    return r;
  endfunction

  function automatic row_t asg(int v, logic [cnfst_pkg::VAL_W-1:0] val);
    row_t r;
    r        = ld($urandom_range(N_CLAUSES-1), $urandom_range(N_LITS-1), v,
                  1'($urandom_range(1)));
    r.it.op  = cnfst_pkg::OP_ASSIGN;
    r.it.val = val;
    return r;
  endfunction

  function automatic row_t reg_row(logic [cnfst_pkg::CFG_IDX_W-1:0] idx, int data);
    row_t r;
    r         = ld(0, 0, 0, 1'b0);
    r.kind    = ROW_CFG;
    r.reg_idx = idx;
    r.reg_val = cnfst_pkg::CFG_DATA_W'(data);
    return r;
  endfunction

  function automatic row_t chk(row_t r, int cnt, bit all_sat, bit bad);
    r.fixed        = 1'b1;
    r.want.cnt     = cnfst_pkg::COUNT_W'(cnt);
    r.want.all_sat = all_sat;
    r.want.bad     = bad;
    return r;
  endfunction

  task automatic wait_for_results();
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b0;
    do @(posedge clk); while (tally_q.size() != 0);
  endtask

  task automatic write_reg(logic [cnfst_pkg::CFG_IDX_W-1:0] idx,
                           logic [cnfst_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == cnfst_pkg::CFG_NUM_CLAUSES) nc_reg = data;
    else nv_reg = data[cnfst_pkg::NVARS_W-1:0];
  endtask

  task automatic offer(item_t it, bit fixed, tally_t want);
    tally_t pred;
    cfg_ch.valid <= 1'b0;
    if (!calm && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= it.op;
    in_ch.clause_index <= it.cidx;
    in_ch.lit_slot     <= it.slot;
    in_ch.var_index    <= it.vidx;
    in_ch.negated      <= it.neg;
    in_ch.value        <= it.val;
    do @(posedge clk); while (!in_ch.ready);
    pred = track_clauses(it);
    tally_q.push_back(fixed ? want : pred);
    items_taken++;
  endtask

  // result side: random back-pressure plus one long hold-off
  initial begin : result_side
    tally_t got;
    tally_t w;
    int     hold_left;
    bit     held;
    hold_left     = 0;
    held          = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.cnt     = out_ch.satisfied_count;
        got.all_sat = out_ch.all_satisfied;
        got.bad     = out_ch.bad_index;
        if (tally_q.size() == 0) begin
          miss($sformatf("unexpected result cnt=%0d all=%0b bad=%0b",
                         got.cnt, got.all_sat, got.bad));
        end else begin
          w = tally_q.pop_front();
          if (got.cnt != w.cnt)
            miss($sformatf("satisfied_count exp %0d got %0d", w.cnt, got.cnt));
          if (got.all_sat != w.all_sat)
            miss($sformatf("all_satisfied exp %0b got %0b", w.all_sat, got.all_sat));
          if (got.bad != w.bad)
            miss($sformatf("bad_index exp %0b got %0b", w.bad, got.bad));
        end
      end
      if (!held && items_taken >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 30);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    row_t   rw;
    phase_t p;
    err_cnt     = 0;
    items_taken = 0;
    calm        = 1'b0;
    true_cnt    = 0;
    nc_reg      = '0;
    nv_reg      = '0;
    foreach (lit_mem[i]) begin
      lit_mem[i]     = '0;
      slot_loaded[i] = 1'b0;
    end
    foreach (var_val[i]) var_val[i] = cnfst_pkg::VAL_UNASSIGNED;
    foreach (clause_on[i]) clause_on[i] = 1'b0;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= cnfst_pkg::OP_LOAD;
    in_ch.clause_index <= '0;
    in_ch.lit_slot     <= '0;
    in_ch.var_index    <= '0;
    in_ch.negated      <= 1'b0;
    in_ch.value        <= cnfst_pkg::VAL_FALSE;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.idx         <= cnfst_pkg::CFG_NUM_CLAUSES;
    cfg_ch.data        <= '0;

    // reset configuration: no clause and no variable in range
    dir_tbl.push_back(chk(ld(0, 0, 0, 1'b0), 0, 1'b1, 1'b1));
    dir_tbl.push_back(chk(asg(1, cnfst_pkg::VAL_TRUE), 0, 1'b1, 1'b1));
    dir_tbl.push_back(chk(asg(0, cnfst_pkg::VAL_TRUE), 0, 1'b1, 1'b1));
    dir_tbl.push_back(reg_row(cnfst_pkg::CFG_NUM_CLAUSES, 2));
    dir_tbl.push_back(reg_row(cnfst_pkg::CFG_NUM_VARS, N_VARS));
    // clause 0 = x255 | ~x1, clause 1 empty
    dir_tbl.push_back(ld(0, 0, 255, 1'b0));
    dir_tbl.push_back(ld(0, 1, 1, 1'b1));
    dir_tbl.push_back(ld(0, 2, 0, 1'b1));
    dir_tbl.push_back(ld(0, 3, 0, 1'b0));
    for (int s = 0; s < N_LITS; s++) dir_tbl.push_back(ld(1, s, 0, 1'b0));
    dir_tbl.push_back(chk(ld(2, 0, 1, 1'b0), 0, 1'b0, 1'b1));
    dir_tbl.push_back(chk(ld(1023, 3, 255, 1'b1), 0, 1'b0, 1'b1));
    dir_tbl.push_back(asg(255, cnfst_pkg::VAL_TRUE));
    dir_tbl.push_back(asg(1, cnfst_pkg::VAL_FALSE));
    dir_tbl.push_back(asg(255, VAL_RESERVED));
    dir_tbl.push_back(asg(1, cnfst_pkg::VAL_UNASSIGNED));
    dir_tbl.push_back(asg(1, cnfst_pkg::VAL_FALSE));
    dir_tbl.push_back(reg_row(cnfst_pkg::CFG_NUM_CLAUSES, 1));
    dir_tbl.push_back(asg(255, cnfst_pkg::VAL_FALSE));
    // shrunk to zero clauses: stale flag of clause 0 still counts
    dir_tbl.push_back(reg_row(cnfst_pkg::CFG_NUM_CLAUSES, 0));
    dir_tbl.push_back(asg(1, cnfst_pkg::VAL_TRUE));
    dir_tbl.push_back(chk(ld(0, 0, 1, 1'b0), 1, 1'b0, 1'b1));
    dir_tbl.push_back(reg_row(cnfst_pkg::CFG_NUM_VARS, 5));
    dir_tbl.push_back(reg_row(cnfst_pkg::CFG_NUM_CLAUSES, 2));
    dir_tbl.push_back(chk(ld(1, 0, 6, 1'b0), 1, 1'b0, 1'b1));
    // late load: clause 1 changes only at the next assign of x5
    dir_tbl.push_back(ld(1, 0, 5, 1'b0));
    dir_tbl.push_back(chk(asg(6, cnfst_pkg::VAL_TRUE), 1, 1'b0, 1'b1));
    dir_tbl.push_back(asg(5, cnfst_pkg::VAL_TRUE));
    dir_tbl.push_back(asg(1, cnfst_pkg::VAL_TRUE));

    plan.push_back('{6, 8, 8, 110, 1'b0});
    plan.push_back('{12, 20, 12, 100, 1'b0});
    plan.push_back('{1024, 255, 255, 30, 1'b0});
    plan.push_back('{2047, 0, 4, 25, 1'b0});
    plan.push_back('{3, 255, 6, 90, 1'b1});
    plan.push_back('{16, 4, 4, 90, 1'b0});
    plan.push_back('{1, 1, 1, 40, 1'b0});
    plan.push_back('{0, 255, 10, 25, 1'b0});
    plan.push_back('{10, 255, 255, 60, 1'b0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i]) begin
      rw = dir_tbl[i];
      if (rw.kind == ROW_CFG) begin
        wait_for_results();
        write_reg(rw.reg_idx, rw.reg_val);
      end else begin
        offer(rw.it, rw.fixed, rw.want);
      end
    end

    foreach (plan[k]) begin
      p = plan[k];
      wait_for_results();
      write_reg(cnfst_pkg::CFG_NUM_CLAUSES, cnfst_pkg::CFG_DATA_W'(p.nc));
      write_reg(cnfst_pkg::CFG_NUM_VARS, cnfst_pkg::CFG_DATA_W'(p.nv));
      calm = p.calm;
      for (int j = 0; j < p.n_items; j++) begin
        if (j == p.n_items / 2) wait_for_results();
        offer(make_item(p.vpool), 1'b0, '0);
      end
      calm = 1'b0;
    end

    wait_for_results();
    repeat (40) @(posedge clk);
    if (tally_q.size() != 0) miss($sformatf("%0d results never arrived", tally_q.size()));
    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
